/* hw/rtl/fctng_pkg.sv */
// shared constants, codes and attenuation table for the tone and noise generator
`default_nettype none

package fctng_pkg;

	// input clock ticks per generation step
	localparam int CLOCK_DIVIDE = 16;
	localparam int PRESCALE_W = (CLOCK_DIVIDE > 1) ? $clog2(CLOCK_DIVIDE) : 1;
	localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(CLOCK_DIVIDE - 1);

	localparam int NUM_CH   = 4;
	localparam int NUM_TONE = 3;
	localparam int PERIOD_W = 10;
	localparam int ATT_W    = 4;
	localparam int LEVEL_W  = 15;
	localparam int SUM_W    = LEVEL_W + 2;

	// request kinds carried in tuser
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// channel select code of the noise channel
	localparam logic [1:0] CH_NOISE = 2'd3;

	// noise rate select codes
	localparam logic [1:0] RATE_16  = 2'd0;
	localparam logic [1:0] RATE_32  = 2'd1;
	localparam logic [1:0] RATE_64  = 2'd2;
	localparam logic [1:0] RATE_TONE2 = 2'd3;

	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_16 = 10'h010;
	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_32 = 10'h020;
	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_64 = 10'h040;

	localparam logic [15:0] NOISE_SEED = 16'h8000;

	// 2 dB steps, round(32767 * 10^(-i/10)), silent at the last step
	function automatic logic [LEVEL_W-1:0] att_level(input logic [ATT_W-1:0] att);
		logic [LEVEL_W-1:0] lvl;
		case (att)
			4'd0:    lvl = 15'd32767;
			4'd1:    lvl = 15'd26028;
			4'd2:    lvl = 15'd20675;
			4'd3:    lvl = 15'd16422;
			4'd4:    lvl = 15'd13045;
			4'd5:    lvl = 15'd10362;
			4'd6:    lvl = 15'd8231;
			4'd7:    lvl = 15'd6538;
			4'd8:    lvl = 15'd5193;
			4'd9:    lvl = 15'd4125;
			4'd10:   lvl = 15'd3277;
			4'd11:   lvl = 15'd2603;
			4'd12:   lvl = 15'd2067;
			4'd13:   lvl = 15'd1642;
			4'd14:   lvl = 15'd1304;
			default: lvl = 15'd0;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/four_channel_tone_noise_generator.sv */
// top level of the four-channel tone and noise sound generator
`default_nettype none

// three square-wave tone channels and one noise channel driven by a request
// stream. each request is either a register write byte (tuser = 0) or one
// input clock tick (tuser = 1). every CLOCK_DIVIDE ticks a generation step
// runs; when mixer_enable is set that step emits one result: the sum of the
// attenuated levels of the sounding channels divided by four (Q0.15) plus
// the per-channel sounding bits. a request is taken every cycle unless the
// input is stalled: it is registered, then applied to the channel state as
// the result is written into the output register. the result register is
// single, and the input stage keeps taking requests while it is full and
// stalled only when both the input stage and the result are held.
// mixer_enable is written through the cfg channel, always ready; the user must write it only while idle, unenforced.
module four_channel_tone_noise_generator
	import fctng_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data
	input  wire logic        s_axis_tuser,  // [0] kind

	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata,  // [14:0] sample, [18:15] channel_bits, [23:19] zero

	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic        cfg_data       // mixer_enable
);

	// request stage
	logic       req_valid_s1;
	logic       req_kind_s1;
	logic [7:0] req_data_s1;

	// result register
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_sample_q;
	logic [NUM_CH-1:0]   out_bits_q;

	// channel state
	logic                  mixer_q;
	logic [PERIOD_W-1:0]   period_q [NUM_TONE];
	logic [2:0]            nctl_q;
	logic [ATT_W-1:0]      attn_q   [NUM_CH];
	logic [PERIOD_W-1:0]   cnt_q    [NUM_CH];
	logic [NUM_CH-1:0]     phase_q;
	logic [15:0]           noise_q;
	logic [1:0]            lch_q;
	logic                  lvol_q;
	logic [PRESCALE_W-1:0] pre_q;

	// next state
	logic [PERIOD_W-1:0]   period_d [NUM_TONE];
	logic [2:0]            nctl_d;
	logic [ATT_W-1:0]      attn_d   [NUM_CH];
	logic [PERIOD_W-1:0]   cnt_d    [NUM_CH];
	logic [NUM_CH-1:0]     phase_d;
	logic [15:0]           noise_d;
	logic [1:0]            lch_d;
	logic                  lvol_d;
	logic [PRESCALE_W-1:0] pre_d;

	logic                  advance;
	logic                  s1_fire;
	logic                  gen_step;
	logic                  emit;
	logic [NUM_CH-1:0]     sound;
	logic [SUM_W-1:0]      sum;

	// the request stage moves on whenever the result register is free or draining
	assign advance       = !out_valid_q || m_axis_tready;
	assign s1_fire       = req_valid_s1 && advance;
	assign s_axis_tready = !req_valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_bits_q, out_sample_q};

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			req_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_kind_s1 <= s_axis_tuser;
			req_data_s1 <= s_axis_tdata;
		end
	end

	// apply one request to the channel state
	always_comb begin
		logic [PERIOD_W-1:0] dec;
		logic [PERIOD_W-1:0] ndec;
		logic                fb;

		period_d = period_q;
		nctl_d   = nctl_q;
		attn_d   = attn_q;
		cnt_d    = cnt_q;
		phase_d  = phase_q;
		noise_d  = noise_q;
		lch_d    = lch_q;
		lvol_d   = lvol_q;
		pre_d    = pre_q;
		gen_step = 1'b0;
		dec      = '0;
		ndec     = '0;
		fb       = 1'b0;

		if (s1_fire) begin
			if (req_kind_s1 == KIND_WRITE) begin
				// latch byte picks channel and type first, then both kinds write
				if (req_data_s1[7]) begin
					lch_d  = req_data_s1[6:5];
					lvol_d = req_data_s1[4];
				end
				if (lvol_d) begin
					attn_d[lch_d] = req_data_s1[3:0];
				end else if (lch_d == CH_NOISE) begin
					// any noise register write restarts the shifter
					nctl_d  = req_data_s1[2:0];
					noise_d = NOISE_SEED;
				end else if (req_data_s1[7]) begin
					period_d[lch_d] = {period_q[lch_d][9:4], req_data_s1[3:0]};
				end else begin
					period_d[lch_d] = {req_data_s1[5:0], period_q[lch_d][3:0]};
				end
			end else begin
				if (pre_q == PRESCALE_LAST) begin
					pre_d    = '0;
					gen_step = 1'b1;
				end else begin
					pre_d = pre_q + 1'b1;
				end
			end
		end

		if (gen_step) begin
			// tone channels: wrap-around down-counter, toggle and reload at zero
			for (int c = 0; c < NUM_TONE; c++) begin
				dec = cnt_q[c] - 1'b1;
				if (dec == '0) begin
					phase_d[c] = ~phase_q[c];
					cnt_d[c]   = period_q[c];
				end else begin
					cnt_d[c] = dec;
				end
			end
			// noise channel: shifter clocks on the rising edge of its phase
			ndec = cnt_q[CH_NOISE] - 1'b1;
			if (ndec == '0) begin
				phase_d[CH_NOISE] = ~phase_q[CH_NOISE];
				case (nctl_q[1:0])
					RATE_16: cnt_d[CH_NOISE] = NOISE_RELOAD_16;
					RATE_32: cnt_d[CH_NOISE] = NOISE_RELOAD_32;
					RATE_64: cnt_d[CH_NOISE] = NOISE_RELOAD_64;
					default: cnt_d[CH_NOISE] = period_q[2];
				endcase
				if (phase_d[CH_NOISE]) begin
					// white mode taps bits 0 and 3, periodic mode recirculates bit 0
					fb      = nctl_q[2] ? (noise_q[0] ^ noise_q[3]) : noise_q[0];
					noise_d = {fb, noise_q[15:1]};
				end
			end else begin
				cnt_d[CH_NOISE] = ndec;
			end
		end
	end

	// mix the stepped state; a period below two holds a tone channel high
	always_comb begin
		for (int c = 0; c < NUM_TONE; c++) begin
			sound[c] = phase_d[c] || (period_q[c] < 10'd2);
		end
		sound[CH_NOISE] = noise_d[0];
		sum = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (sound[c]) begin
				sum = sum + SUM_W'(att_level(attn_q[c]));
			end
		end
	end

	assign emit = gen_step && mixer_q;

	// channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mixer_q <= 1'b1;
			for (int c = 0; c < NUM_TONE; c++) begin
				period_q[c] <= '0;
			end
			for (int c = 0; c < NUM_CH; c++) begin
				attn_q[c] <= '1;
				cnt_q[c]  <= '0;
			end
			phase_q <= '0;
			nctl_q  <= '0;
			noise_q <= NOISE_SEED;
			lch_q   <= '0;
			lvol_q  <= 1'b0;
			pre_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mixer_q <= cfg_data;
			end
			period_q <= period_d;
			attn_q   <= attn_d;
			cnt_q    <= cnt_d;
			phase_q  <= phase_d;
			nctl_q   <= nctl_d;
			noise_q  <= noise_d;
			lch_q    <= lch_d;
			lvol_q   <= lvol_d;
			pre_q    <= pre_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_sample_q <= sum[SUM_W-1:2];
			out_bits_q   <= sound;
		end
	end

`ifndef SYNTHESIS
	// a register write never creates a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && req_kind_s1 == KIND_WRITE && !out_valid_q) |=> !out_valid_q)
		else $error("register write produced a result");

	// the shifter map is invertible, so it can never lock up at zero
	a_noise_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		noise_q != 16'h0000)
		else $error("noise shifter reached zero");

	// a new result only appears when the mixer was enabled
	a_mixer_gate: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(mixer_q))
		else $error("result emitted with mixer disabled");

	// prescaler only moves on a tick request
	a_prescale_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pre_q != $past(pre_q)) |-> $past(s1_fire && req_kind_s1 == KIND_TICK))
		else $error("prescaler moved without a tick");
`endif

endmodule

`default_nettype wire

/* tb/tone_noise_checker.sv */
// tone and noise generator checker: predicts each mixed sample and compares the result stream
`timescale 1ns / 100ps

module tone_noise_checker
	import fctng_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data
	input  wire logic        s_axis_tuser,  // [0] kind

	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,  // [14:0] sample, [18:15] channel_bits, [23:19] zero

	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_data,      // mixer_enable

	output int               pending_results,
	output int               mismatch_count
);

	typedef struct packed {
		logic [LEVEL_W-1:0] sample;
		logic [3:0]         channel_bits;
	} mix_result_t;

	localparam logic [LEVEL_W-1:0] LEVEL_OF_ATT [16] = '{
		15'd32767, 15'd26028, 15'd20675, 15'd16422, 15'd13045, 15'd10362, 15'd8231, 15'd6538,
		15'd5193,  15'd4125,  15'd3277,  15'd2603,  15'd2067,  15'd1642,  15'd1304, 15'd0
	};

	logic [PERIOD_W-1:0] period_reg [NUM_TONE];
	logic [2:0]          noise_ctl;
	logic [ATT_W-1:0]    att_reg [NUM_CH];
	logic [PERIOD_W-1:0] step_cnt [NUM_CH];
	logic                phase_bit [NUM_CH];
	logic [15:0]         noise_sr;
	logic [1:0]          sel_channel;
	logic                sel_volume;
	int                  ticks_in_step;
	logic                mixer_on;
	int                  fail_total;

	mix_result_t expected_samples [$];

	task automatic apply_register_byte(input logic [7:0] d);
		if (d[7]) begin
			sel_channel = d[6:5];
			sel_volume  = d[4];
		end
		if (sel_volume) begin
			att_reg[sel_channel] = d[3:0];
		end else if (sel_channel == CH_NOISE) begin
			noise_ctl = d[2:0];
			noise_sr  = NOISE_SEED;
		end else if (d[7]) begin
			period_reg[sel_channel][3:0] = d[3:0];
		end else begin
			period_reg[sel_channel][9:4] = d[5:0];
		end
	endtask

	// one generation step of all four channels, returns the mixed level
	task automatic advance_generator(output mix_result_t res);
		logic [SUM_W-1:0] sum;
		logic             fb;
		sum = '0;
		res = '0;
		for (int c = 0; c < NUM_TONE; c++) begin
			step_cnt[c] = step_cnt[c] - 1'b1;
			if (step_cnt[c] == '0) begin
				phase_bit[c] = ~phase_bit[c];
				step_cnt[c]  = period_reg[c];
			end
			if (phase_bit[c] || period_reg[c] < 2) begin
				sum = sum + SUM_W'(LEVEL_OF_ATT[att_reg[c]]);
				res.channel_bits[c] = 1'b1;
			end
		end
		step_cnt[CH_NOISE] = step_cnt[CH_NOISE] - 1'b1;
		if (step_cnt[CH_NOISE] == '0) begin
			phase_bit[CH_NOISE] = ~phase_bit[CH_NOISE];
			case (noise_ctl[1:0])
				RATE_16: begin
					step_cnt[CH_NOISE] = NOISE_RELOAD_16;
				end
				RATE_32: begin
					step_cnt[CH_NOISE] = NOISE_RELOAD_32;
				end
				RATE_64: begin
					step_cnt[CH_NOISE] = NOISE_RELOAD_64;
				end
				default: begin
					step_cnt[CH_NOISE] = period_reg[2];
				end
			endcase
			if (phase_bit[CH_NOISE]) begin
				fb = noise_ctl[2] ? (noise_sr[0] ^ noise_sr[3]) : noise_sr[0];
				noise_sr = {fb, noise_sr[15:1]};
			end
		end
		if (noise_sr[0]) begin
			sum = sum + SUM_W'(LEVEL_OF_ATT[att_reg[CH_NOISE]]);
			res.channel_bits[CH_NOISE] = 1'b1;
		end
		res.sample = LEVEL_W'(sum >> 2);
	endtask

	task automatic note_mismatch(input bit had_expect, input mix_result_t want,
			input mix_result_t got);
		fail_total++;
		if (fail_total <= 10) begin
			if (had_expect)
				$display("mismatch: expected sample %0d bits %b, got sample %0d bits %b",
					want.sample, want.channel_bits, got.sample, got.channel_bits);
			else
				$display("unexpected result: sample %0d bits %b", got.sample, got.channel_bits);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_result_t got;
		mix_result_t want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_TONE; c++)
				period_reg[c] = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				att_reg[c]   = '1;
				step_cnt[c]  = '0;
				phase_bit[c] = 1'b0;
			end
			noise_ctl     = '0;
			noise_sr      = NOISE_SEED;
			sel_channel   = '0;
			sel_volume    = 1'b0;
			ticks_in_step = 0;
			mixer_on      = 1'b1;
			fail_total    = 0;
			expected_samples.delete();
			pending_results <= 0;
			mismatch_count  <= 0;
		end else begin
			// a result can never come from a request taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample       = m_axis_tdata[14:0];
				got.channel_bits = m_axis_tdata[18:15];
				if (expected_samples.size() == 0) begin
					note_mismatch(1'b0, '0, got);
				end else begin
					want = expected_samples.pop_front();
					if (got.sample !== want.sample || got.channel_bits !== want.channel_bits)
						note_mismatch(1'b1, want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				mixer_on = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == KIND_WRITE) begin
					apply_register_byte(s_axis_tdata);
				end else begin
					ticks_in_step++;
					if (ticks_in_step == CLOCK_DIVIDE) begin
						ticks_in_step = 0;
						advance_generator(want);
						if (mixer_on)
							expected_samples.push_back(want);
					end
				end
			end
			pending_results <= expected_samples.size();
			mismatch_count  <= fail_total;
		end
	end

endmodule

/* tb/four_channel_tone_noise_generator_tb.sv */
// testbench top for the tone and noise generator: stimulus, stalls and verdict
`timescale 1ns / 100ps

module four_channel_tone_noise_generator_tb;
	import fctng_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tuser  = KIND_WRITE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic        cfg_data      = 1'b0;

	int pending_results;
	int mismatch_count;

	// stimulus side controls
	bit quiet;          // no idling on either side
	bit hold_request;   // ask the receiver for one long hold-off
	bit hold_served;
	int sent_items;
	int cycles;

	four_channel_tone_noise_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	tone_noise_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request, none when quiet
	initial begin
		hold_served = 1'b0;
		forever begin
			if (hold_request && !hold_served) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// one request on the input stream, with an occasional idle burst ahead of it;
	// valid stays high between back-to-back requests
	task automatic send_request(input logic kind, input logic [7:0] d);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_request(KIND_TICK, 8'($urandom));
	endtask

	// let every expected result arrive, then give the pipeline time to empty
	task automatic wait_until_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mixer_enable(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random register traffic: mostly well-formed latch plus data pairs, some stray bytes
	task automatic send_random_group();
		int          pick;
		logic [1:0]  ch;
		logic [9:0]  per;
		logic [3:0]  att;
		pick = $urandom_range(0, 9);
		ch   = 2'($urandom_range(0, 2));
		per  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
		att  = 4'($urandom);
		case (pick)
			0, 1, 2: begin
				// tone period, low nibble then high six bits, stray bit 6 random
				send_request(KIND_WRITE, {1'b1, ch, 1'b0, per[3:0]});
				send_request(KIND_WRITE, {1'b0, 1'($urandom), per[9:4]});
			end
			3: begin
				ch = 2'($urandom);
				send_request(KIND_WRITE, {1'b1, ch, 1'b1, att});
				if ($urandom_range(0, 1) == 0)
					send_request(KIND_WRITE, {1'b0, 3'($urandom), 4'($urandom)});
			end
			4: begin
				send_request(KIND_WRITE, {1'b1, CH_NOISE, 1'b0, 4'($urandom)});
				if ($urandom_range(0, 2) == 0)
					send_request(KIND_WRITE, {1'b0, 7'($urandom)});
			end
			5: begin
				send_request(KIND_WRITE, 8'($urandom));
			end
			default: begin
				send_ticks($urandom_range(1, 48));
			end
		endcase
	endtask

	initial begin
		int phase_start;
		quiet        = 1'b0;
		hold_request = 1'b0;
		sent_items   = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of periods and levels, short periods, every noise rate
		write_mixer_enable(1'b1);
		send_request(KIND_WRITE, 8'h8F);  // ch0 tone low nibble all ones
		send_request(KIND_WRITE, 8'h7F);  // high bits all ones, stray bit 6 set
		send_request(KIND_WRITE, 8'h90);  // ch0 loudest
		send_request(KIND_WRITE, 8'hA1);  // ch1 period one, always sounds
		send_request(KIND_WRITE, 8'h00);
		send_request(KIND_WRITE, 8'hB5);
		send_request(KIND_WRITE, 8'h4A);  // volume through a data byte, stray bit
		send_request(KIND_WRITE, 8'hC0);  // ch2 period zero
		send_request(KIND_WRITE, 8'h00);
		send_request(KIND_WRITE, 8'hDE);
		send_request(KIND_WRITE, 8'hE7);  // white noise clocked by ch2
		send_request(KIND_WRITE, 8'hF0);
		send_ticks(32);
		send_request(KIND_WRITE, 8'hE0);  // periodic, fastest rate
		send_request(KIND_WRITE, 8'h7D);  // noise data byte with stray bits
		send_ticks(64);
		send_request(KIND_WRITE, 8'hC2);
		send_request(KIND_WRITE, 8'h00);
		send_ticks(48);
		send_request(KIND_WRITE, 8'hE2);  // slowest fixed rate
		send_ticks(64);
		send_request(KIND_WRITE, 8'hFF);  // noise silent
		send_request(KIND_WRITE, 8'h9F);  // ch0 silent

		// noise clocked by a zero period on ch2, whose counter wraps to the top count
		send_request(KIND_WRITE, 8'hF0);
		send_request(KIND_WRITE, 8'hC0);
		send_request(KIND_WRITE, 8'h00);
		send_request(KIND_WRITE, 8'hE3);
		send_ticks(CLOCK_DIVIDE * 4);
		wait_until_idle();

		// mixer off: steps still advance but nothing comes out
		write_mixer_enable(1'b0);
		phase_start = sent_items;
		while (sent_items - phase_start < 60)
			send_random_group();
		wait_until_idle();

		// mixer back on, start with a long receiver hold-off while ticks keep coming
		write_mixer_enable(1'b1);
		hold_request = 1'b1;
		send_ticks(120);
		phase_start = sent_items;
		while (sent_items - phase_start < 140) begin
			if (sent_items - phase_start >= 100)
				quiet = 1'b1;
			send_random_group();
		end
		quiet = 1'b1;
		wait_until_idle();

		if (mismatch_count == 0 && pending_results == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/fctng_pkg.sv
hw/rtl/four_channel_tone_noise_generator.sv
tb/tone_noise_checker.sv
tb/four_channel_tone_noise_generator_tb.sv
